[hw/rtl/hrlp_pkg.sv]
// Shared types, constants and character tables of the HTTP request line parser.
package hrlp_pkg;

   // Length of the connection header text that is searched for.
   localparam int HdrLen = 22;
   localparam logic [HdrLen*8-1:0] HdrText = "Connection: keep-alive";

   // Token bookkeeping constants.
   localparam logic [3:0] PosMax = 4'd15;
   localparam logic [3:0] VerLen = 4'd8;
   localparam logic [4:0] MethodAll = 5'b11111;
   localparam logic [1:0] VersionAll = 2'b11;

   // Delimiter characters.
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChLf = 8'h0A;
   localparam logic [7:0] ChCr = 8'h0D;

   // Result kinds.
   localparam logic KindPath = 1'b0;
   localparam logic KindSummary = 1'b1;

   // Version codes.
   localparam logic Ver10 = 1'b0;
   localparam logic Ver11 = 1'b1;

   // Result queue size.
   localparam int FifoDepth = 4;
   localparam int FifoAw = $clog2(FifoDepth);
   localparam int FifoCw = $clog2(FifoDepth + 1);

   typedef enum logic [1:0] {
      PHASE_METHOD,
      PHASE_PATH,
      PHASE_VERSION,
      PHASE_REST
   } phase_type;

   typedef enum logic [2:0] {
      METHOD_NONE,
      METHOD_GET,
      METHOD_PUT,
      METHOD_POST,
      METHOD_HEAD,
      METHOD_DELETE
   } method_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] path_byte;
      method_type method;
      logic       version;
      logic       keep_alive;
      logic       last;
   } result_type;

   // Results produced by one accepted byte: an optional path result and an
   // optional summary result, in that order.
   typedef struct packed {
      logic       path_valid;
      result_type path;
      logic       sum_valid;
      result_type summary;
   } push_type;

   // Control of the header search cells.
   typedef struct packed {
      logic step;
      logic clear;
   } search_ctrl_type;

   // Character of the header text at a given place, first character at zero.
   function automatic logic [7:0] hdr_char(input int idx);
      hdr_char = HdrText[(HdrLen-1-idx)*8 +: 8];
   endfunction

   // Methods whose text holds this byte at this place; bit 0 is GET.
   function automatic logic [4:0] method_hits(input logic [3:0] pos, input logic [7:0] b);
      logic [4:0] hits;
      hits = '0;
      case (pos)
         4'd0: hits = {b == "D", b == "H", b == "P", b == "P", b == "G"};
         4'd1: hits = {b == "E", b == "E", b == "O", b == "U", b == "E"};
         4'd2: hits = {b == "L", b == "A", b == "S", b == "T", b == "T"};
         4'd3: hits = {b == "E", b == "D", b == "T", 2'b00};
         4'd4: hits = {b == "T", 4'b0000};
         4'd5: hits = {b == "E", 4'b0000};
         default: hits = '0;
      endcase
      return hits;
   endfunction

   // Versions whose text holds this byte at this place; bit 0 is 1.1.
   function automatic logic [1:0] version_hits(input logic [3:0] pos, input logic [7:0] b);
      logic [1:0] hits;
      hits = '0;
      case (pos)
         4'd0: hits = {2{b == "H"}};
         4'd1: hits = {2{b == "T"}};
         4'd2: hits = {2{b == "T"}};
         4'd3: hits = {2{b == "P"}};
         4'd4: hits = {2{b == "/"}};
         4'd5: hits = {2{b == "1"}};
         4'd6: hits = {2{b == "."}};
         4'd7: hits = {b == "0", b == "1"};
         default: hits = '0;
      endcase
      return hits;
   endfunction

   // Method named by a finished token, the first full match in list order.
   function automatic method_type finish_method(input logic [3:0] pos,
                                                input logic [4:0] cand);
      method_type m;
      if (cand[0] && pos == 4'd3) begin
         m = METHOD_GET;
      end else if (cand[1] && pos == 4'd3) begin
         m = METHOD_PUT;
      end else if (cand[2] && pos == 4'd4) begin
         m = METHOD_POST;
      end else if (cand[3] && pos == 4'd4) begin
         m = METHOD_HEAD;
      end else if (cand[4] && pos == 4'd6) begin
         m = METHOD_DELETE;
      end else begin
         m = METHOD_NONE;
      end
      return m;
   endfunction

   // Version named by a finished token; anything but an exact 1.0 gives 1.1.
   function automatic logic finish_version(input logic [3:0] pos, input logic [1:0] cand);
      logic v;
      if (pos == VerLen && !cand[0] && cand[1]) begin
         v = Ver10;
      end else begin
         v = Ver11;
      end
      return v;
   endfunction

endpackage

[hw/rtl/hrlp_match_cell.sv]
// One cell of the header search chain: tracks one prefix length of the header text.
module hrlp_match_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  hrlp_pkg::search_ctrl_type ctrl,
   input  logic [7:0]              msg_byte,
   input  logic [7:0]              pattern,
   input  logic                    prev_hit,
   output logic                    hit_next,
   output logic                    hit_ff
);

   logic hit_in;

   // The prefix grows by one when the neighbor held the shorter prefix
   // and this byte is the next character.
   assign hit_next = prev_hit && (msg_byte == pattern);

   always_comb begin
      hit_in = hit_ff;
      if (ctrl.clear) begin
         hit_in = 1'b0;
      end else if (ctrl.step) begin
         hit_in = hit_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule

[hw/rtl/hrlp_hdr_search.sv]
// Chain of match cells that finds the keep-alive connection header in the message tail.
module hrlp_hdr_search (
   input  logic                      clock,
   input  logic                      reset,
   input  hrlp_pkg::search_ctrl_type ctrl,
   input  logic [7:0]                msg_byte,
   output logic                      found_now
);

   logic [hrlp_pkg::HdrLen:0]   chain;
   logic                        last_next;
   logic                        found_ff;
   logic                        found_in;
   hrlp_pkg::search_ctrl_type   cell_ctrl;

   // The empty prefix always matches; once found, the chain stops stepping.
   assign chain[0] = 1'b1;
   assign cell_ctrl.step = ctrl.step && !found_ff;
   assign cell_ctrl.clear = ctrl.clear;

   genvar gi;
   generate
      for (gi = 0; gi < hrlp_pkg::HdrLen; gi = gi + 1) begin : g_cell
         if (gi == hrlp_pkg::HdrLen - 1) begin : g_last
            hrlp_match_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (cell_ctrl),
               .msg_byte (msg_byte),
               .pattern  (hrlp_pkg::hdr_char(gi)),
               .prev_hit (chain[gi]),
               .hit_next (last_next),
               .hit_ff   (chain[gi+1])
            );
         end else begin : g_mid
            hrlp_match_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .ctrl     (cell_ctrl),
               .msg_byte (msg_byte),
               .pattern  (hrlp_pkg::hdr_char(gi)),
               .prev_hit (chain[gi]),
               .hit_next (),
               .hit_ff   (chain[gi+1])
            );
         end
      end
   endgenerate

   // Found flag including the byte being taken now, so a summary sees it.
   assign found_now = found_ff || (cell_ctrl.step && last_next);

   always_comb begin
      found_in = found_now;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

endmodule

[hw/rtl/hrlp_token_parser.sv]
// Token tracker: splits the request line into method, path and version tokens.
module hrlp_token_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                msg_byte,
   input  logic                      end_of_message,
   input  logic                      header_found,
   output hrlp_pkg::search_ctrl_type search_ctrl,
   output hrlp_pkg::push_type        push
);

   hrlp_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]           pos_ff, pos_in;
   logic [4:0]           mcand_ff, mcand_in;
   logic [1:0]           vcand_ff, vcand_in;
   hrlp_pkg::method_type mcode_ff, mcode_in;
   logic                 vcode_ff, vcode_in;

   logic                 delim;
   logic                 path_byte_seen;
   hrlp_pkg::method_type fin_method;
   logic                 fin_version;

   assign delim = (msg_byte == hrlp_pkg::ChSpace) || (msg_byte == hrlp_pkg::ChLf) ||
                  (msg_byte == hrlp_pkg::ChCr);

   // Effect of one byte on the token state.
   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      mcand_in = mcand_ff;
      vcand_in = vcand_ff;
      mcode_in = mcode_ff;
      vcode_in = vcode_ff;
      path_byte_seen = 1'b0;
      if (phase_ff == hrlp_pkg::PHASE_REST) begin
         // Tail bytes only feed the header search.
      end else if (delim) begin
         if (phase_ff == hrlp_pkg::PHASE_METHOD) begin
            mcode_in = hrlp_pkg::finish_method(pos_ff, mcand_ff);
         end
         if (phase_ff == hrlp_pkg::PHASE_VERSION) begin
            vcode_in = hrlp_pkg::finish_version(pos_ff, vcand_ff);
         end
         phase_in = hrlp_pkg::phase_type'(phase_ff + 2'd1);
         pos_in = '0;
         mcand_in = hrlp_pkg::MethodAll;
         vcand_in = hrlp_pkg::VersionAll;
      end else begin
         if (phase_ff == hrlp_pkg::PHASE_METHOD) begin
            mcand_in = mcand_ff & hrlp_pkg::method_hits(pos_ff, msg_byte);
         end else if (phase_ff == hrlp_pkg::PHASE_VERSION) begin
            vcand_in = vcand_ff & hrlp_pkg::version_hits(pos_ff, msg_byte);
         end else begin
            path_byte_seen = 1'b1;
         end
         if (pos_ff != hrlp_pkg::PosMax) begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   // A message that ends inside the method or version token finishes it.
   always_comb begin
      fin_method = mcode_in;
      fin_version = vcode_in;
      if (phase_in == hrlp_pkg::PHASE_METHOD) begin
         fin_method = hrlp_pkg::finish_method(pos_in, mcand_in);
      end
      if (phase_in == hrlp_pkg::PHASE_VERSION) begin
         fin_version = hrlp_pkg::finish_version(pos_in, vcand_in);
      end
   end

   // Results for the result queue.
   always_comb begin
      push.path_valid = accept && path_byte_seen;
      push.path.kind = hrlp_pkg::KindPath;
      push.path.path_byte = msg_byte;
      push.path.method = hrlp_pkg::METHOD_NONE;
      push.path.version = 1'b0;
      push.path.keep_alive = 1'b0;
      push.path.last = !end_of_message;
      push.sum_valid = accept && end_of_message;
      push.summary.kind = hrlp_pkg::KindSummary;
      push.summary.path_byte = '0;
      push.summary.method = fin_method;
      push.summary.version = fin_version;
      push.summary.keep_alive = header_found;
      push.summary.last = 1'b1;
   end

   assign search_ctrl.step = accept && (phase_ff == hrlp_pkg::PHASE_REST);
   assign search_ctrl.clear = accept && end_of_message;

   // Token state; the end of a message returns it to the start values.
   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_message)) begin
         phase_ff <= hrlp_pkg::PHASE_METHOD;
         pos_ff <= '0;
         mcand_ff <= hrlp_pkg::MethodAll;
         vcand_ff <= hrlp_pkg::VersionAll;
         mcode_ff <= hrlp_pkg::METHOD_NONE;
         vcode_ff <= hrlp_pkg::Ver11;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         mcand_ff <= mcand_in;
         vcand_ff <= vcand_in;
         mcode_ff <= mcode_in;
         vcode_ff <= vcode_in;
      end
   end

endmodule

[hw/rtl/hrlp_result_fifo.sv]
// Small result queue that takes up to two results a cycle and hands out one while out_ready is high.
module hrlp_result_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  hrlp_pkg::push_type   push,
   input  logic                 out_ready,
   output logic                 out_valid,
   output hrlp_pkg::result_type out_data,
   output logic                 room_for_two
);

   hrlp_pkg::result_type           mem_ff [hrlp_pkg::FifoDepth];
   logic [hrlp_pkg::FifoAw-1:0]    wr_ff, wr_in;
   logic [hrlp_pkg::FifoAw-1:0]    rd_ff, rd_in;
   logic [hrlp_pkg::FifoCw-1:0]    cnt_ff, cnt_in;
   logic [hrlp_pkg::FifoAw-1:0]    wr_sum;
   logic [hrlp_pkg::FifoAw-1:0]    n_push;
   logic                           pop;

   assign out_valid = (cnt_ff != '0);
   assign out_data = mem_ff[rd_ff];
   assign pop = out_valid && out_ready;
   assign room_for_two = (cnt_ff <= hrlp_pkg::FifoCw'(hrlp_pkg::FifoDepth - 2));

   // The summary lands behind the path result of the same byte.
   assign wr_sum = wr_ff + hrlp_pkg::FifoAw'(push.path_valid);
   assign n_push = hrlp_pkg::FifoAw'(push.path_valid) + hrlp_pkg::FifoAw'(push.sum_valid);

   always_comb begin
      wr_in = wr_ff + n_push;
      rd_in = rd_ff + hrlp_pkg::FifoAw'(pop);
      cnt_in = cnt_ff + hrlp_pkg::FifoCw'(n_push) - hrlp_pkg::FifoCw'(pop);
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push.path_valid) begin
         mem_ff[wr_ff] <= push.path;
      end
      if (push.sum_valid) begin
         mem_ff[wr_sum] <= push.summary;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[hw/rtl/http_request_line_parser.sv]
// Top level of the HTTP request line parser.
//
// The request comes in on the req_ stream one byte per transfer, with
// req_tlast on the final byte of a message. Bytes of the path token come
// out on the rsp_ stream as path results (rsp_tuser low). The final byte
// of a message also gives a summary result (rsp_tuser high) with the
// method, the version and whether the keep-alive connection header was
// seen; rsp_tlast marks the final result caused by an input byte.
// Throughput is one byte per cycle while req_tready is high. A result is put
// in the queue at the transfer of the byte that causes it. A final byte that
// is also a path byte gives two results: the path result, then the summary.
// The header search is a chain of 22 match cells, one per header character,
// each stepping once per tail byte until the header is found. Results wait
// in a four-entry queue; req_tready is high while at most two results are
// waiting, so a stalled receiver holds off the input once three or more
// results are waiting, and nothing is lost. Reset empties the queue; reset
// and the final byte of a message return the parser to a message start.
module http_request_line_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] path_byte, [10:8] method, [11] version,
                                    // [12] keep_alive, [15:13] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast
);

   logic                      accept;
   logic                      header_found;
   hrlp_pkg::search_ctrl_type search_ctrl;
   hrlp_pkg::push_type        push;
   hrlp_pkg::result_type      rsp;
   logic                      room_for_two;

   assign req_tready = room_for_two;
   assign accept = req_tvalid && req_tready;

   hrlp_token_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .msg_byte       (req_tdata),
      .end_of_message (req_tlast),
      .header_found   (header_found),
      .search_ctrl    (search_ctrl),
      .push           (push)
   );

   hrlp_hdr_search u_search (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (search_ctrl),
      .msg_byte  (req_tdata),
      .found_now (header_found)
   );

   hrlp_result_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .out_ready    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_data     (rsp),
      .room_for_two (room_for_two)
   );

   // Pack the result fields onto the output stream.
   assign rsp_tdata = {3'b000, rsp.keep_alive, rsp.version, rsp.method, rsp.path_byte};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

[tb/sv/testbench.sv]
// Self-checking stream testbench for the HTTP request line parser.
`timescale 1ns / 1ps

module testbench;

   // One input byte of the stimulus; directed rows may carry a typed summary method.
   typedef struct {
      logic [7:0]           msg_byte;
      logic                 eom;
      logic                 typed;
      hrlp_pkg::method_type sum_method;
   } stim_row_type;

   localparam int RandomItems = 1850;
   localparam int VersionChars = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // [7:0] path_byte, [10:8] method, [11] version,
                             // [12] keep_alive, [15:13] zero
   logic        rsp_tuser;   // [0] kind
   logic        rsp_tlast;

   // Texts that the parser recognizes; list order gives the method codes.
   string method_text[5] = '{"GET", "PUT", "POST", "HEAD", "DELETE"};
   string version_text[2] = '{"HTTP/1.1", "HTTP/1.0"};
   string hdr_pattern = "Connection: keep-alive";

   // Parser state as predicted by the testbench.
   hrlp_pkg::phase_type  p_phase;
   logic [3:0]           p_tok_len;
   logic [4:0]           p_meth_live;
   logic [1:0]           p_ver_live;
   hrlp_pkg::method_type p_meth_found;
   logic                 p_ver_found;
   logic [4:0]           p_hdr_matched;
   logic                 p_keep_seen;

   hrlp_pkg::result_type results_due[$];
   stim_row_type         request_table[$];
   logic [7:0]           msg_bytes[$];
   int                   sent_count = 0;
   int                   mismatches = 0;
   logic                 hold_off = 1'b0;
   logic                 calm = 1'b0;

   http_request_line_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Return the predicted parser to the start of a message.
   task automatic clear_parser();
      p_phase = hrlp_pkg::PHASE_METHOD;
      p_tok_len = '0;
      p_meth_live = hrlp_pkg::MethodAll;
      p_ver_live = hrlp_pkg::VersionAll;
      p_meth_found = hrlp_pkg::METHOD_NONE;
      p_ver_found = hrlp_pkg::Ver11;
      p_hdr_matched = '0;
      p_keep_seen = 1'b0;
   endtask

   // Settle the method or the version from the token that just ended.
   task automatic close_token();
      if (p_phase == hrlp_pkg::PHASE_METHOD) begin
         p_meth_found = hrlp_pkg::METHOD_NONE;
         for (int i = 0; i < 5; i++) begin
            if (p_meth_live[i] && method_text[i].len() == p_tok_len &&
                p_meth_found == hrlp_pkg::METHOD_NONE) begin
               p_meth_found = hrlp_pkg::method_type'(i + 1);
            end
         end
      end else if (p_phase == hrlp_pkg::PHASE_VERSION) begin
         if (p_tok_len == VersionChars && p_ver_live[0]) begin
            p_ver_found = hrlp_pkg::Ver11;
         end else if (p_tok_len == VersionChars && p_ver_live[1]) begin
            p_ver_found = hrlp_pkg::Ver10;
         end else begin
            p_ver_found = hrlp_pkg::Ver11;
         end
      end
   endtask

   // Advance the predicted parser by one byte and queue the results it causes.
   task automatic parse_byte(input logic [7:0] b, input logic eom);
      hrlp_pkg::result_type r;
      logic                 delim;
      delim = (b == hrlp_pkg::ChSpace || b == hrlp_pkg::ChLf || b == hrlp_pkg::ChCr);
      if (p_phase == hrlp_pkg::PHASE_REST) begin
         // Header search; a mismatching 'C' starts a new match.
         if (!p_keep_seen && p_hdr_matched < hdr_pattern.len()) begin
            if (b == hdr_pattern[p_hdr_matched]) begin
               p_hdr_matched++;
            end else begin
               p_hdr_matched = (b == "C") ? 5'd1 : 5'd0;
            end
            if (p_hdr_matched >= hdr_pattern.len()) begin
               p_keep_seen = 1'b1;
            end
         end
      end else if (delim) begin
         close_token();
         p_phase = hrlp_pkg::phase_type'(p_phase + 1);
         p_tok_len = '0;
         p_meth_live = hrlp_pkg::MethodAll;
         p_ver_live = hrlp_pkg::VersionAll;
      end else begin
         case (p_phase)
            hrlp_pkg::PHASE_METHOD: begin
               for (int i = 0; i < 5; i++) begin
                  if (p_tok_len >= method_text[i].len() ||
                      method_text[i][p_tok_len] != b) begin
                     p_meth_live[i] = 1'b0;
                  end
               end
            end
            hrlp_pkg::PHASE_VERSION: begin
               for (int i = 0; i < 2; i++) begin
                  if (p_tok_len >= VersionChars || version_text[i][p_tok_len] != b) begin
                     p_ver_live[i] = 1'b0;
                  end
               end
            end
            default: begin
               r = '0;
               r.kind = hrlp_pkg::KindPath;
               r.path_byte = b;
               r.method = hrlp_pkg::METHOD_NONE;
               r.last = !eom;
               results_due.push_back(r);
            end
         endcase
         if (p_tok_len < hrlp_pkg::PosMax) begin
            p_tok_len++;
         end
      end

      // The final byte finishes any open method or version token and reports.
      if (eom) begin
         if (p_phase == hrlp_pkg::PHASE_METHOD || p_phase == hrlp_pkg::PHASE_VERSION) begin
            close_token();
         end
         r = '0;
         r.kind = hrlp_pkg::KindSummary;
         r.method = p_meth_found;
         r.version = p_ver_found;
         r.keep_alive = p_keep_seen;
         r.last = 1'b1;
         results_due.push_back(r);
         clear_parser();
      end
   endtask

   // Gap length shared by both sides: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 70) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] rand_delim();
      int roll;
      roll = $urandom_range(0, 2);
      return (roll == 0) ? hrlp_pkg::ChSpace :
             ((roll == 1) ? hrlp_pkg::ChCr : hrlp_pkg::ChLf);
   endfunction

   // A byte that never ends a token, mostly printable, else any non-delimiter value.
   function automatic logic [7:0] rand_plain();
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 99) < 70) begin
            b = 8'($urandom_range(33, 126));
         end else begin
            b = 8'($urandom_range(0, 255));
         end
      end while (b == hrlp_pkg::ChSpace || b == hrlp_pkg::ChLf || b == hrlp_pkg::ChCr);
      return b;
   endfunction

   // A text with one character replaced or its tail cut off.
   function automatic string broken(input string s);
      string t;
      t = s;
      if ($urandom_range(0, 1) == 0) begin
         t[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(33, 126));
      end else begin
         t = s.substr(0, $urandom_range(0, s.len() - 2));
      end
      return t;
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         msg_bytes.push_back(s[i]);
      end
   endtask

   task automatic add_plain(input int n);
      repeat (n) msg_bytes.push_back(rand_plain());
   endtask

   // Any byte value, with delimiters made frequent.
   task automatic add_noise(input int n);
      repeat (n) begin
         if ($urandom_range(0, 99) < 30) begin
            msg_bytes.push_back(rand_delim());
         end else begin
            msg_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Build one random message: mostly a request line and header lines, else noise or plain bytes.
   task automatic build_message();
      int pick;
      int n;
      int cut;
      msg_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         n = $urandom_range(0, 9);
         if (n < 5) begin
            add_text(method_text[n]);
         end else if (n == 5) begin
            add_text(method_text[$urandom_range(0, 4)].substr(0, $urandom_range(0, 2)));
         end else if (n == 6) begin
            add_text(method_text[$urandom_range(0, 4)]);
            msg_bytes.push_back(rand_plain());
         end else begin
            add_plain($urandom_range(0, 17));
         end
         msg_bytes.push_back(rand_delim());

         // Path token, mostly short.
         add_plain(($urandom_range(0, 99) < 90) ? $urandom_range(0, 8) : $urandom_range(9, 20));
         msg_bytes.push_back(rand_delim());

         n = $urandom_range(0, 99);
         if (n < 45) begin
            add_text(version_text[1]);
         end else if (n < 80) begin
            add_text(version_text[0]);
         end else if (n < 90) begin
            add_text(broken(version_text[$urandom_range(0, 1)]));
         end else begin
            add_plain($urandom_range(0, 12));
         end
         msg_bytes.push_back(rand_delim());

         // Header lines, with the keep-alive text whole, broken or after a stray 'C'.
         repeat ($urandom_range(0, 3)) begin
            n = $urandom_range(0, 99);
            if (n < 40) begin
               add_text(hdr_pattern);
            end else if (n < 60) begin
               add_text(broken(hdr_pattern));
            end else if (n < 70) begin
               add_text({"C", hdr_pattern.substr(0, $urandom_range(0, 21))});
            end else if (n < 80) begin
               add_text("Connection: close");
            end else begin
               add_noise($urandom_range(0, 12));
            end
            msg_bytes.push_back(hrlp_pkg::ChCr);
            msg_bytes.push_back(hrlp_pkg::ChLf);
         end

         // Sometimes the message stops early, inside any token.
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut) begin
               void'(msg_bytes.pop_back());
            end
         end
      end else if (pick < 92) begin
         add_noise($urandom_range(1, 20));
      end else begin
         add_plain($urandom_range(1, 3));
      end
   endtask

   // Offer one byte, wait for its transfer, then predict its results.
   task automatic offer_byte(input stim_row_type row);
      int                   gap;
      hrlp_pkg::result_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row.msg_byte;
      req_tlast <= row.eom;
      do @(posedge clock); while (!req_tready);
      parse_byte(row.msg_byte, row.eom);
      // Directed summaries expect HTTP/1.1 and no keep-alive.
      if (row.typed) begin
         r = results_due.pop_back();
         r.method = row.sum_method;
         r.version = hrlp_pkg::Ver11;
         r.keep_alive = 1'b0;
         results_due.push_back(r);
      end
      sent_count++;
      @(negedge clock);
   endtask

   task automatic table_row(input logic [7:0] b, input logic eom,
                            input hrlp_pkg::method_type m);
      stim_row_type row;
      row.msg_byte = b;
      row.eom = eom;
      row.typed = eom;
      row.sum_method = m;
      request_table.push_back(row);
   endtask

   // Stimulus: directed table, then random messages.
   initial begin : stimulus
      stim_row_type row;
      clear_parser();

      // A lone 0xFF byte ends the message at once.
      table_row(8'hFF, 1'b1, hrlp_pkg::METHOD_NONE);
      // GET, PUT, POST and DELETE, each message ending inside its method token.
      table_row("G", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("E", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("T", 1'b1, hrlp_pkg::METHOD_GET);
      table_row("P", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("U", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("T", 1'b1, hrlp_pkg::METHOD_PUT);
      table_row("P", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("O", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("S", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("T", 1'b1, hrlp_pkg::METHOD_POST);
      table_row("D", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("E", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("L", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("E", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("T", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("E", 1'b1, hrlp_pkg::METHOD_DELETE);
      // A zero path byte that is also the final byte gives two results.
      table_row("H", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("E", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("A", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row("D", 1'b0, hrlp_pkg::METHOD_NONE);
      table_row(hrlp_pkg::ChSpace, 1'b0, hrlp_pkg::METHOD_NONE);
      table_row(8'h00, 1'b1, hrlp_pkg::METHOD_HEAD);
      // Empty method, path and version tokens.
      table_row(hrlp_pkg::ChSpace, 1'b0, hrlp_pkg::METHOD_NONE);
      table_row(hrlp_pkg::ChCr, 1'b0, hrlp_pkg::METHOD_NONE);
      table_row(hrlp_pkg::ChLf, 1'b1, hrlp_pkg::METHOD_NONE);

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (request_table[i]) begin
         offer_byte(request_table[i]);
      end

      while (sent_count < request_table.size() + RandomItems) begin
         build_message();
         foreach (msg_bytes[k]) begin
            row.msg_byte = msg_bytes[k];
            row.eom = (k == msg_bytes.size() - 1);
            row.typed = 1'b0;
            row.sum_method = hrlp_pkg::METHOD_NONE;
            offer_byte(row);
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then allow a few more cycles for any stray result.
      while (results_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result receiver with random stalls and the long hold-off.
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Hold the receiver off long enough for the result queue to fill and stall the input.
   initial begin : long_stall
      wait (sent_count >= 400);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (150) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Alternate stretches of random gaps with stretches of none.
   initial begin : gap_mode
      forever begin
         repeat ($urandom_range(300, 600)) @(posedge clock);
         calm <= !calm;
      end
   end

   // Compare every result transfer with the oldest expected result.
   always @(posedge clock) begin : rsp_check
      hrlp_pkg::result_type want;
      logic [15:0]          want_data;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result tuser=%0b tdata=%h tlast=%0b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            want_data = {3'b000, want.keep_alive, want.version, want.method, want.path_byte};
            if (rsp_tuser !== want.kind || rsp_tdata !== want_data ||
                rsp_tlast !== want.last) begin
               $display({"%0t: mismatch, expected kind=%0b path=%h method=%0d",
                         " ver=%0b ka=%0b last=%0b"},
                        $time, want.kind, want.path_byte, want.method, want.version,
                        want.keep_alive, want.last);
               $display({"%0t:           actual kind=%0b path=%h method=%0d",
                         " ver=%0b ka=%0b last=%0b pad=%0b"},
                        $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8], rsp_tdata[11],
                        rsp_tdata[12], rsp_tlast, rsp_tdata[15:13]);
               mismatches++;
            end
         end
      end
   end

   // Watchdog.
   initial begin : watchdog
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
